[src/decimal_integer_rounding_top_assert.svh]
// Assertion macros for the decimal integer rounding block.
// Used by decimal_integer_rounding_top; needs clk and rst_n in scope.
`ifndef DECIMAL_INTEGER_ROUNDING_TOP_ASSERT_SVH
`define DECIMAL_INTEGER_ROUNDING_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define DIR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define DIR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/dir_pkg.sv]
// Shared types and constants of the decimal integer rounding block.
// Used by dir_div10 and decimal_integer_rounding_top; no dependencies.
package dir_pkg;

    localparam int MANT_W     = 96;
    localparam int CHUNK_W    = 16;
    localparam int NUM_CHUNKS = MANT_W / CHUNK_W;
    localparam int CHUNK_IDX_W = 3;
    localparam int REM_W      = 4;
    localparam int SCALE_W    = 5;
    localparam int STEP_W     = REM_W + CHUNK_W;

    // floor(2^23 / 10): quotient estimate is exact or one low for 20-bit inputs
    localparam int RECIP_SHIFT = 23;
    localparam logic [STEP_W-1:0] RECIP = STEP_W'((64'd1 << RECIP_SHIFT) / 10);
    localparam logic [REM_W:0] TEN = 5'd10;

    typedef enum logic [1:0] {
        OP_FLOOR    = 2'd0,
        OP_ROUND    = 2'd1,
        OP_TRUNCATE = 2'd2,
        OP_SPARE    = 2'd3
    } op_t;

    typedef logic [NUM_CHUNKS-1:0][CHUNK_W-1:0] mant_t;

    typedef struct packed {
        logic [CHUNK_W-1:0] quot;
        logic [REM_W-1:0]   rem;
    } div_res_t;

endpackage

[src/decimal_integer_rounding_top.sv]
// Decimal round-to-integer block: sequencer, mantissa register and output stage.
// Depends on dir_pkg, dir_div10 and decimal_integer_rounding_top_assert.svh.
//
// Turns a 96-bit decimal mantissa with a power-of-ten scale into an integer by
// floor, round half away from zero or truncate; the sign is passed through and
// scales above MAX_SCALE saturate. One item is worked on at a time: a single
// 16-bit divide-by-ten step walks the six mantissa chunks once per decimal digit
// of the scale taken after saturation (no pass for scale zero), followed by the
// 96-bit increment and the load of the output register, which waits while the
// output register stays full with m_tready low. s_tready is high only while no
// item is at work; a result waiting in the output register does not block the
// next item.
`include "decimal_integer_rounding_top_assert.svh"

module decimal_integer_rounding_top
    import dir_pkg::*;
#(
    parameter int MAX_SCALE = 28
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // operation[1:0], mant_low[33:2], mant_mid[65:34], mant_high[97:66],
    // scale[102:98], negative[103]
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // res_low[31:0], res_mid[63:32], res_high[95:64], res_negative[96], zero[103:97]
    output logic [103:0] m_tdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FIX,
        S_OUT
    } state_t;

    localparam logic [SCALE_W-1:0] SCALE_CAP = SCALE_W'(MAX_SCALE);
    localparam logic [CHUNK_IDX_W-1:0] LAST_CHUNK = CHUNK_IDX_W'(NUM_CHUNKS - 1);
    localparam logic [REM_W-1:0] HALF_DIGIT = 4'd5;

    state_t                 state_reg, state_next;
    mant_t                  mant_reg, mant_next;
    logic [CHUNK_IDX_W-1:0] chunk_reg, chunk_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [SCALE_W-1:0]     left_reg, left_next;
    logic [REM_W-1:0]       last_reg, last_next;
    logic                   lost_reg, lost_next;
    logic                   scaled_reg, scaled_next;
    op_t                    op_reg, op_next;
    logic                   neg_reg, neg_next;
    logic                   out_valid_reg, out_valid_next;
    logic [MANT_W-1:0]      res_reg, res_next;
    logic                   res_neg_reg, res_neg_next;

    logic [SCALE_W-1:0]     scale_in;
    logic [SCALE_W-1:0]     scale_sat;
    logic                   accept;
    logic                   out_free;
    logic                   bump;
    div_res_t               step;

    dir_div10 u_div10
    (
        .rem_in (rem_reg),
        .chunk  (mant_reg[chunk_reg]),
        .res    (step)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign scale_in = s_tdata[102:98];
    assign scale_sat = (scale_in > SCALE_CAP) ? SCALE_CAP : scale_in;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, res_neg_reg, res_reg};

    always_comb
    begin
        bump = 1'b0;
        case (op_reg)
            OP_FLOOR: bump = neg_reg && lost_reg;
            OP_ROUND: bump = (last_reg >= HALF_DIGIT);
            default:  bump = 1'b0;
        endcase
        bump = bump && scaled_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        mant_next      = mant_reg;
        chunk_next     = chunk_reg;
        rem_next       = rem_reg;
        left_next      = left_reg;
        last_next      = last_reg;
        lost_next      = lost_reg;
        scaled_next    = scaled_reg;
        op_next        = op_reg;
        neg_next       = neg_reg;
        res_next       = res_reg;
        res_neg_next   = res_neg_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = op_t'(s_tdata[1:0]);
                    mant_next   = mant_t'(s_tdata[97:2]);
                    neg_next    = s_tdata[103];
                    left_next   = scale_sat;
                    scaled_next = (scale_sat != '0);
                    chunk_next  = LAST_CHUNK;
                    rem_next    = '0;
                    last_next   = '0;
                    lost_next   = 1'b0;
                    state_next  = (scale_sat != '0) ? S_DIV : S_FIX;
                end
            end
            S_DIV:
            begin
                mant_next[chunk_reg] = step.quot;
                if (chunk_reg == '0)
                begin
                    last_next  = step.rem;
                    lost_next  = lost_reg || (step.rem != '0);
                    rem_next   = '0;
                    chunk_next = LAST_CHUNK;
                    left_next  = left_reg - 1'b1;
                    if (left_reg == SCALE_W'(1))
                    begin
                        state_next = S_FIX;
                    end
                end
                else
                begin
                    rem_next   = step.rem;
                    chunk_next = chunk_reg - 1'b1;
                end
            end
            S_FIX:
            begin
                mant_next  = mant_t'(MANT_W'(mant_reg) + {{(MANT_W-1){1'b0}}, bump});
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    res_next       = MANT_W'(mant_reg);
                    res_neg_next   = neg_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            chunk_reg     <= '0;
            left_reg      <= '0;
            mant_reg      <= '0;
            rem_reg       <= '0;
            last_reg      <= '0;
            lost_reg      <= 1'b0;
            scaled_reg    <= 1'b0;
            op_reg        <= OP_FLOOR;
            neg_reg       <= 1'b0;
            res_reg       <= '0;
            res_neg_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            chunk_reg     <= chunk_next;
            left_reg      <= left_next;
            mant_reg      <= mant_next;
            rem_reg       <= rem_next;
            last_reg      <= last_next;
            lost_reg      <= lost_next;
            scaled_reg    <= scaled_next;
            op_reg        <= op_next;
            neg_reg       <= neg_next;
            res_reg       <= res_next;
            res_neg_reg   <= res_neg_next;
        end
    end

    `DIR_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, !s_tready,
        "accepted item did not make the block busy")
    `DIR_ASSERT_NOW(a_div_has_digits, state_reg == S_DIV, left_reg != '0,
        "divide step running with no digits left")
    `DIR_ASSERT_NOW(a_chunk_range, state_reg == S_DIV, chunk_reg <= LAST_CHUNK,
        "chunk index beyond the mantissa")
    `DIR_ASSERT_NEXT(a_out_load, (state_reg == S_OUT) && (!m_tvalid || m_tready),
        m_tvalid && s_tready, "finished result not loaded into the output stage")

endmodule

[src/dir_div10.sv]
// One long-division step by ten over a 16-bit chunk with a carried remainder.
// Depends on dir_pkg.
module dir_div10
    import dir_pkg::*;
(
    input  logic [REM_W-1:0]   rem_in,
    input  logic [CHUNK_W-1:0] chunk,
    output div_res_t           res
);

    logic [STEP_W-1:0]   dividend;
    logic [2*STEP_W-1:0] prod;
    logic [CHUNK_W-1:0]  quot_est;
    logic [STEP_W-1:0]   back;
    logic [STEP_W-1:0]   diff;
    logic [REM_W:0]      rem_est;

    always_comb
    begin
        dividend = {rem_in, chunk};
        prod     = dividend * RECIP;
        quot_est = prod[RECIP_SHIFT +: CHUNK_W];
        back     = {{REM_W{1'b0}}, quot_est} * STEP_W'(TEN);
        diff     = dividend - back;
        rem_est  = diff[REM_W:0];
        if (rem_est >= TEN)
        begin
            res.quot = quot_est + 1'b1;
            res.rem  = REM_W'(rem_est - TEN);
        end
        else
        begin
            res.quot = quot_est;
            res.rem  = rem_est[REM_W-1:0];
        end
    end

endmodule
